[rtl/kslp_pkg.sv]
// ----------------------------------------------------------------------------
// kslp_pkg
// Shared types and codes for the key_share list parser.
// ----------------------------------------------------------------------------
`default_nettype none

package kslp_pkg;

	localparam logic [1:0] KIND_KEY  = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [1:0] ERR_LIST_LONG  = 2'd0;
	localparam logic [1:0] ERR_HDR_TRUNC  = 2'd1;
	localparam logic [1:0] ERR_KEY_OVERRUN = 2'd2;
	localparam logic [1:0] ERR_KEY_EMPTY  = 2'd3;

	// data holds the group for a key byte, the count for done, the code for an error
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] data;
		logic [7:0]  kbyte;
		logic        last;
	} kslp_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} kslp_q_stat_t;

endpackage

`default_nettype wire

[rtl/kslp_front.sv]
// ----------------------------------------------------------------------------
// kslp_front
// Byte parser: walks the list header and entries, emits one result record
// per accepted byte where the body calls for one.
// ----------------------------------------------------------------------------
`default_nettype none

module kslp_front (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     accept,
	input  wire [7:0]               body_byte,
	input  wire                     start_req,
	input  wire [15:0]              ext_len,
	output logic                    rec_push,
	output kslp_pkg::kslp_rec_t     rec
);

	typedef enum logic [7:0] {
		PH_IDLE    = 8'b0000_0001,
		PH_LEN_LO  = 8'b0000_0010,
		PH_GRP_HI  = 8'b0000_0100,
		PH_GRP_LO  = 8'b0000_1000,
		PH_KLEN_HI = 8'b0001_0000,
		PH_KLEN_LO = 8'b0010_0000,
		PH_KEY     = 8'b0100_0000,
		PH_DONE    = 8'b1000_0000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] list_q, list_d;
	logic [7:0]  held_q, held_d;
	logic [15:0] grp_q, grp_d;
	logic [15:0] key_q, key_d;
	logic [13:0] ent_q, ent_d;
	logic [15:0] word;
	logic [15:0] list_m1;

	assign word    = {held_q, body_byte};
	assign list_m1 = list_q - 16'd1;

	always_comb begin
		phase_d  = phase_q;
		list_d   = list_q;
		held_d   = held_q;
		grp_d    = grp_q;
		key_d    = key_q;
		ent_d    = ent_q;
		rec_push = 1'b0;
		rec      = '0;
		if (accept) begin
			// flush a pending done ahead of whatever this byte does
			if (phase_q == PH_DONE) begin
				rec_push  = 1'b1;
				rec.kind  = kslp_pkg::KIND_DONE;
				rec.data  = {2'b00, ent_q};
				phase_d   = PH_IDLE;
			end
			if (start_req) begin
				held_d  = body_byte;
				list_d  = ext_len;
				grp_d   = '0;
				key_d   = '0;
				ent_d   = '0;
				phase_d = PH_LEN_LO;
			end else begin
				unique case (phase_q)
					PH_LEN_LO: begin
						if (list_q < 16'd2 || word > (list_q - 16'd2)) begin
							rec_push = 1'b1;
							rec.kind = kslp_pkg::KIND_ERR;
							rec.data = {14'd0, kslp_pkg::ERR_LIST_LONG};
							phase_d  = PH_IDLE;
						end else if (word == 16'd0) begin
							rec_push = 1'b1;
							rec.kind = kslp_pkg::KIND_DONE;
							list_d   = word;
							phase_d  = PH_IDLE;
						end else begin
							list_d  = word;
							phase_d = PH_GRP_HI;
						end
					end
					PH_GRP_HI: begin
						if (list_q < 16'd4) begin
							rec_push = 1'b1;
							rec.kind = kslp_pkg::KIND_ERR;
							rec.data = {14'd0, kslp_pkg::ERR_HDR_TRUNC};
							phase_d  = PH_IDLE;
						end else begin
							held_d  = body_byte;
							list_d  = list_m1;
							phase_d = PH_GRP_LO;
						end
					end
					PH_GRP_LO: begin
						grp_d   = word;
						list_d  = list_m1;
						phase_d = PH_KLEN_HI;
					end
					PH_KLEN_HI: begin
						held_d  = body_byte;
						list_d  = list_m1;
						phase_d = PH_KLEN_LO;
					end
					PH_KLEN_LO: begin
						list_d = list_m1;
						if (word == 16'd0) begin
							rec_push = 1'b1;
							rec.kind = kslp_pkg::KIND_ERR;
							rec.data = {14'd0, kslp_pkg::ERR_KEY_EMPTY};
							phase_d  = PH_IDLE;
						end else if (word > list_m1) begin
							rec_push = 1'b1;
							rec.kind = kslp_pkg::KIND_ERR;
							rec.data = {14'd0, kslp_pkg::ERR_KEY_OVERRUN};
							phase_d  = PH_IDLE;
						end else begin
							key_d   = word;
							phase_d = PH_KEY;
						end
					end
					PH_KEY: begin
						list_d    = list_m1;
						key_d     = key_q - 16'd1;
						rec_push  = 1'b1;
						rec.kind  = kslp_pkg::KIND_KEY;
						rec.data  = grp_q;
						rec.kbyte = body_byte;
						rec.last  = (key_q == 16'd1);
						if (key_q == 16'd1) begin
							ent_d   = ent_q + 14'd1;
							phase_d = (list_q == 16'd1) ? PH_DONE : PH_GRP_HI;
						end
					end
					PH_IDLE, PH_DONE: begin
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			list_q  <= '0;
			held_q  <= '0;
			grp_q   <= '0;
			key_q   <= '0;
			ent_q   <= '0;
		end else begin
			phase_q <= phase_d;
			list_q  <= list_d;
			held_q  <= held_d;
			grp_q   <= grp_d;
			key_q   <= key_d;
			ent_q   <= ent_d;
		end
	end

endmodule

`default_nettype wire

[rtl/kslp_fifo.sv]
// ----------------------------------------------------------------------------
// kslp_fifo
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module kslp_fifo #(
	parameter int DEPTH = 4
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     push,
	input  kslp_pkg::kslp_rec_t     wdata,
	input  wire                     pop,
	output kslp_pkg::kslp_rec_t     rdata,
	output kslp_pkg::kslp_q_stat_t  stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	kslp_pkg::kslp_rec_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/kslp_back.sv]
// ----------------------------------------------------------------------------
// kslp_back
// Output stage: takes records from the queue and presents them as results.
// ----------------------------------------------------------------------------
`default_nettype none

module kslp_back (
	input  wire                     clk,
	input  wire                     arst_n,
	input  kslp_pkg::kslp_rec_t     rec,
	input  wire                     rec_avail,
	output logic                    rec_take,
	input  wire                     pop,
	output logic                    empty,
	output logic [1:0]              kind,
	output logic [15:0]             group_id,
	output logic [7:0]              key_byte,
	output logic                    key_last,
	output logic [13:0]             entry_count,
	output logic [1:0]              error_code
);

	logic                valid_q;
	kslp_pkg::kslp_rec_t rec_q;

	assign empty    = !valid_q;
	assign rec_take = rec_avail && (!valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rec_take) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_take) begin
			rec_q <= rec;
		end
	end

	always_comb begin
		kind        = rec_q.kind;
		group_id    = '0;
		key_byte    = '0;
		key_last    = 1'b0;
		entry_count = '0;
		error_code  = '0;
		unique case (rec_q.kind)
			kslp_pkg::KIND_KEY: begin
				group_id = rec_q.data;
				key_byte = rec_q.kbyte;
				key_last = rec_q.last;
			end
			kslp_pkg::KIND_DONE: begin
				entry_count = rec_q.data[13:0];
			end
			kslp_pkg::KIND_ERR: begin
				error_code = rec_q.data[1:0];
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/key_share_list_parser_core.sv]
// ----------------------------------------------------------------------------
// key_share_list_parser_core
// Byte-serial parser for a key_share extension body, with a result queue.
//
//   channel   | direction | handshake          | payload
//   ----------+-----------+--------------------+-------------------------------
//   body in   | input     | push / full        | body_byte, start_req, ext_len
//   result    | output    | empty / pop        | kind, group_id, key_byte,
//             |           |                    | key_last, entry_count,
//             |           |                    | error_code
//
// One byte per cycle is taken while full is low; each byte is parsed in the
// cycle it is taken. A result record from the parser passes through the queue
// and then the output register before it reaches the ports.
// full rises only when the FIFO_DEPTH-entry queue fills under a stalled pop.
// Reset empties the queue and returns the parser to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module key_share_list_parser_core #(
	parameter int FIFO_DEPTH = 4
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         push,
	output logic        full,
	input  wire  [7:0]  body_byte,
	input  wire         start_req,
	input  wire  [15:0] ext_len,
	output logic        empty,
	input  wire         pop,
	output logic [1:0]  kind,
	output logic [15:0] group_id,
	output logic [7:0]  key_byte,
	output logic        key_last,
	output logic [13:0] entry_count,
	output logic [1:0]  error_code
);

	logic                   accept;
	logic                   rec_push;
	kslp_pkg::kslp_rec_t    rec_in;
	kslp_pkg::kslp_rec_t    rec_out;
	kslp_pkg::kslp_q_stat_t q_stat;
	logic                   rec_take;

	assign full   = q_stat.full;
	assign accept = push && !q_stat.full;

	kslp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.body_byte (body_byte),
		.start_req (start_req),
		.ext_len   (ext_len),
		.rec_push  (rec_push),
		.rec       (rec_in)
	);

	kslp_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_push),
		.wdata  (rec_in),
		.pop    (rec_take),
		.rdata  (rec_out),
		.stat   (q_stat)
	);

	kslp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rec         (rec_out),
		.rec_avail   (!q_stat.empty),
		.rec_take    (rec_take),
		.pop         (pop),
		.empty       (empty),
		.kind        (kind),
		.group_id    (group_id),
		.key_byte    (key_byte),
		.key_last    (key_last),
		.entry_count (entry_count),
		.error_code  (error_code)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		rec_push |-> !q_stat.full)
		else $error("result record pushed into a full queue");

	a_out_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_stat.empty && empty) |=> !empty)
		else $error("output stage idle while queue holds a record");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (kind == kslp_pkg::KIND_KEY || kind == kslp_pkg::KIND_DONE ||
			kind == kslp_pkg::KIND_ERR))
		else $error("result with unknown kind");

	a_nonkey_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind != kslp_pkg::KIND_KEY) |->
			(group_id == 16'd0 && key_byte == 8'd0 && !key_last))
		else $error("key fields set on a non-key result");

endmodule

`default_nettype wire

[test/key_share_list_parser_core_check.sv]
// ----------------------------------------------------------------------------
// key_share_list_parser_core_check
// Watches the body and result queues of the key_share list parser, predicts
// every result from the accepted body bytes and compares each popped result,
// field by field, with the oldest prediction. Mismatches are counted.
// ----------------------------------------------------------------------------
module key_share_list_parser_core_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  body_byte,
	input  logic        start_req,
	input  logic [15:0] ext_len,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  kind,
	input  logic [15:0] group_id,
	input  logic [7:0]  key_byte,
	input  logic        key_last,
	input  logic [13:0] entry_count,
	input  logic [1:0]  error_code,
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {
		P_IDLE, P_LEN_LO, P_GRP_HI, P_GRP_LO, P_KLEN_HI, P_KLEN_LO, P_KEY, P_DONE
	} parse_phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] grp;
		logic [7:0]  kbyte;
		logic        last;
		logic [13:0] count;
		logic [1:0]  code;
	} parse_result_t;

	parse_phase_t  ph       = P_IDLE;
	logic [15:0]   list_rem = '0;
	logic [7:0]    held     = '0;
	logic [15:0]   cur_grp  = '0;
	logic [15:0]   key_rem  = '0;
	logic [13:0]   seen     = '0;
	parse_result_t expected_results[$];
	parse_result_t want;

	function automatic parse_result_t make_result(logic [1:0] k, logic [15:0] g,
			logic [7:0] kb, logic l, logic [13:0] c, logic [1:0] e);
		return {k, g, kb, l, c, e};
	endfunction

	task automatic flag_error(input logic [1:0] code);
		ph = P_IDLE;
		expected_results.push_back(make_result(kslp_pkg::KIND_ERR, 16'd0, 8'd0, 1'b0,
			14'd0, code));
	endtask

	task automatic parse_body_byte(input logic [7:0] b, input logic s, input logic [15:0] elen);
		logic [15:0] v;
		logic        fin;
		v = {held, b};
		if (ph == P_DONE) begin
			expected_results.push_back(make_result(kslp_pkg::KIND_DONE, 16'd0, 8'd0, 1'b0,
				seen, 2'd0));
			ph = P_IDLE;
			if (!s)
				return;
		end
		if (s) begin
			held     = b;
			list_rem = elen;
			cur_grp  = '0;
			key_rem  = '0;
			seen     = '0;
			ph       = P_LEN_LO;
			return;
		end
		case (ph)
			P_LEN_LO: begin
				if (list_rem < 16'd2 || v > list_rem - 16'd2) begin
					flag_error(kslp_pkg::ERR_LIST_LONG);
				end else if (v == 16'd0) begin
					list_rem = '0;
					ph = P_IDLE;
					expected_results.push_back(make_result(kslp_pkg::KIND_DONE, 16'd0, 8'd0,
						1'b0, 14'd0, 2'd0));
				end else begin
					list_rem = v;
					ph = P_GRP_HI;
				end
			end
			P_GRP_HI: begin
				if (list_rem < 16'd4) begin
					flag_error(kslp_pkg::ERR_HDR_TRUNC);
				end else begin
					held = b;
					list_rem = list_rem - 16'd1;
					ph = P_GRP_LO;
				end
			end
			P_GRP_LO: begin
				cur_grp = v;
				list_rem = list_rem - 16'd1;
				ph = P_KLEN_HI;
			end
			P_KLEN_HI: begin
				held = b;
				list_rem = list_rem - 16'd1;
				ph = P_KLEN_LO;
			end
			P_KLEN_LO: begin
				list_rem = list_rem - 16'd1;
				if (v == 16'd0) begin
					flag_error(kslp_pkg::ERR_KEY_EMPTY);
				end else if (v > list_rem) begin
					flag_error(kslp_pkg::ERR_KEY_OVERRUN);
				end else begin
					key_rem = v;
					ph = P_KEY;
				end
			end
			P_KEY: begin
				list_rem = list_rem - 16'd1;
				key_rem  = key_rem - 16'd1;
				fin = (key_rem == 16'd0);
				if (fin) begin
					seen = seen + 14'd1;
					ph = (list_rem == 16'd0) ? P_DONE : P_GRP_HI;
				end
				expected_results.push_back(make_result(kslp_pkg::KIND_KEY, cur_grp, b, fin,
					14'd0, 2'd0));
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] wanted);
		$display("%0t ns: %s got %0h, want %0h", $time, what, got, wanted);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph       = P_IDLE;
			list_rem = '0;
			held     = '0;
			cur_grp  = '0;
			key_rem  = '0;
			seen     = '0;
			expected_results.delete();
			mismatches = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with none pending, kind", {14'd0, kind}, 16'd0);
				end else begin
					want = expected_results.pop_front();
					if (kind !== want.kind)
						report_mismatch("kind", {14'd0, kind}, {14'd0, want.kind});
					if (group_id !== want.grp)
						report_mismatch("group_id", group_id, want.grp);
					if (key_byte !== want.kbyte)
						report_mismatch("key_byte", {8'd0, key_byte}, {8'd0, want.kbyte});
					if (key_last !== want.last)
						report_mismatch("key_last", {15'd0, key_last}, {15'd0, want.last});
					if (entry_count !== want.count)
						report_mismatch("entry_count", {2'd0, entry_count}, {2'd0, want.count});
					if (error_code !== want.code)
						report_mismatch("error_code", {14'd0, error_code}, {14'd0, want.code});
				end
			end
			if (push && !full)
				parse_body_byte(body_byte, start_req, ext_len);
		end
		outstanding = expected_results.size();
	end

endmodule

[test/key_share_list_parser_core_test.sv]
// ----------------------------------------------------------------------------
// key_share_list_parser_core_test
// Drives key_share extension bodies into the parser: a directed set of edge
// cases, then random bodies, mostly well formed, some malformed or cut short,
// with random stalls on both queues. The checker predicts and compares.
// ----------------------------------------------------------------------------
module key_share_list_parser_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS = 1100;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        push      = 1'b0;
	logic [7:0]  body_byte = '0;
	logic        start_req = 1'b0;
	logic [15:0] ext_len   = '0;
	logic        pop       = 1'b0;
	logic        full;
	logic        empty;
	logic [1:0]  kind;
	logic [15:0] group_id;
	logic [7:0]  key_byte;
	logic        key_last;
	logic [13:0] entry_count;
	logic [1:0]  error_code;
	int          mismatches;
	int          outstanding;

	logic [7:0]  body_bytes[$];
	int          items_sent = 0;
	logic        calm       = 1'b0;

	always #10 clk = ~clk;

	key_share_list_parser_core dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.body_byte(body_byte), .start_req(start_req), .ext_len(ext_len),
		.empty(empty), .pop(pop), .kind(kind), .group_id(group_id),
		.key_byte(key_byte), .key_last(key_last), .entry_count(entry_count),
		.error_code(error_code)
	);

	key_share_list_parser_core_check checker_i (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.body_byte(body_byte), .start_req(start_req), .ext_len(ext_len),
		.empty(empty), .pop(pop), .kind(kind), .group_id(group_id),
		.key_byte(key_byte), .key_last(key_last), .entry_count(entry_count),
		.error_code(error_code), .mismatches(mismatches), .outstanding(outstanding)
	);

	task automatic send_byte(input logic [7:0] b, input logic s, input logic [15:0] e);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 9) == 0)
			gap = $urandom_range(1, 16);
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push      <= 1'b1;
		body_byte <= b;
		start_req <= s;
		ext_len   <= e;
		do @(posedge clk); while (full);
	endtask

	task automatic send_body(input logic [15:0] elen, input int count);
		int i;
		for (i = 0; i < count; i++) begin
			send_byte(body_bytes[i], i == 0, (i == 0) ? elen : 16'($urandom));
			items_sent++;
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		push <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic make_random_body(output logic [15:0] elen, output int count);
		int          i, j, n_ent, klen, flaw, trailing;
		logic [15:0] grp;
		logic [15:0] len_field;
		body_bytes.delete();
		flaw  = $urandom_range(0, 15);
		n_ent = $urandom_range(1, 4);
		for (i = 0; i < n_ent; i++) begin
			if (flaw == 12 && i == n_ent - 1)
				klen = 0;
			else if ($urandom_range(0, 7) == 0)
				klen = $urandom_range(9, 40);
			else
				klen = $urandom_range(1, 8);
			grp = 16'($urandom);
			body_bytes.push_back(grp[15:8]);
			body_bytes.push_back(grp[7:0]);
			body_bytes.push_back(8'(klen >> 8));
			body_bytes.push_back(8'(klen));
			for (j = 0; j < klen; j++)
				body_bytes.push_back(8'($urandom));
		end
		// junk after the entries leaves a truncated header
		if (flaw == 13)
			repeat ($urandom_range(1, 3)) body_bytes.push_back(8'($urandom));
		len_field = 16'(body_bytes.size());
		if (flaw == 14)
			len_field = len_field - 16'($urandom_range(1, 3));
		trailing = $urandom_range(0, 3);
		elen = len_field + 16'd2 + 16'(trailing);
		if (flaw == 15)
			elen = len_field + 16'd2 - 16'($urandom_range(1, 2));
		body_bytes.push_front(len_field[7:0]);
		body_bytes.push_front(len_field[15:8]);
		repeat (trailing) body_bytes.push_back(8'($urandom));
		count = body_bytes.size();
		// cut short: the next start aborts the parse
		if (flaw == 11)
			count = $urandom_range(1, count - 1);
	endtask

	initial begin
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (calm || stall == 0) begin
				pop <= 1'b1;
				if (!calm && $urandom_range(0, 11) == 0)
					stall = $urandom_range(1, 16);
			end else begin
				pop <= 1'b0;
				stall--;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		logic [15:0] elen;
		int          count;
		logic        drained;
		drained = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		body_bytes = '{8'h00, 8'h00};
		send_body(16'h0000, 2);
		body_bytes = '{8'hFF, 8'hFF};
		send_body(16'hFFFF, 2);
		body_bytes = '{8'h00, 8'h00};
		send_body(16'h0002, 2);
		body_bytes = '{8'h00, 8'h03, 8'hFF};
		send_body(16'h0005, 3);
		body_bytes = '{8'h00, 8'h04, 8'hFF, 8'hFF, 8'h00, 8'h00};
		send_body(16'h0006, 6);
		body_bytes = '{8'h00, 8'h05, 8'h00, 8'h00, 8'h00, 8'h02};
		send_body(16'h0007, 6);
		body_bytes = '{8'h00, 8'h05, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'hFF};
		send_body(16'hFFFF, 7);
		send_byte(8'hFF, 1'b0, 16'hFFFF);
		drain_results();

		while (items_sent < ITEMS) begin
			if (items_sent > ITEMS - 150)
				calm = 1'b1;
			if (!drained && items_sent > ITEMS / 2) begin
				drain_results();
				drained = 1'b1;
			end
			make_random_body(elen, count);
			send_body(elen, count);
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 16'($urandom));
		end

		@(negedge clk);
		push <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[filelist.f]
rtl/kslp_pkg.sv
rtl/kslp_front.sv
rtl/kslp_fifo.sv
rtl/kslp_back.sv
rtl/key_share_list_parser_core.sv
test/key_share_list_parser_core_check.sv
test/key_share_list_parser_core_test.sv
